// File: rtl/utf8_decode_text_layout_core_macros.svh
// assertion macros for the utf8 text layout core
`ifndef UTF8_DECODE_TEXT_LAYOUT_CORE_MACROS_SVH
`define UTF8_DECODE_TEXT_LAYOUT_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define U8DTL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("u8dtl assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define U8DTL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("u8dtl assertion failed");

`endif

// File: rtl/u8dtl_pkg.sv
// shared types and constants of the utf8 text layout core
`timescale 1ns / 1ps
package u8dtl_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_GLYPH_WIDTH   = 2'd2,
      REG_GLYPH_HEIGHT  = 2'd3
   } reg_index_type;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TEXT  = 1'b1;

   localparam logic [7:0] RST_SCREEN_WIDTH  = 8'd80;
   localparam logic [7:0] RST_SCREEN_HEIGHT = 8'd160;
   localparam logic [5:0] RST_GLYPH_WIDTH   = 6'd8;
   localparam logic [5:0] RST_GLYPH_HEIGHT  = 6'd16;

   typedef struct packed {
      logic [7:0] screen_width;
      logic [7:0] screen_height;
      logic [5:0] glyph_width;
      logic [5:0] glyph_height;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  bytes_pending;
      logic        skipping;
      logic [15:0] partial_code;
      logic [8:0]  cursor_x;
      logic [8:0]  cursor_y;
      logic [7:0]  home_x;
      logic        active;
   } state_type;

   typedef struct packed {
      logic [15:0] code_point;
      logic [8:0]  pos_x;
      logic [8:0]  pos_y;
   } result_type;

endpackage

// File: rtl/u8dtl_if.sv
// request and response channel interfaces of the utf8 text layout core
`timescale 1ns / 1ps
interface u8dtl_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] byte_value;
   logic [7:0] start_x;
   logic [7:0] start_y;

   modport source (output valid, command, byte_value, start_x, start_y, input ready);
   modport sink   (input valid, command, byte_value, start_x, start_y, output ready);
endinterface

interface u8dtl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_point;
   logic [8:0]  pos_x;
   logic [8:0]  pos_y;

   modport source (output valid, code_point, pos_x, pos_y, input ready);
   modport sink   (input valid, code_point, pos_x, pos_y, output ready);
endinterface

// File: rtl/utf8_decode_text_layout_core.sv
// Top level of the utf8 text layout core. A start request (command 0) opens a string at
// (start_x, start_y); text requests (command 1) then carry one utf8 byte each, and every
// finished 1-, 2- or 3-byte sequence not wrapped off the bottom leaves as one response with
// its code point and glyph cell. Four-byte sequences and stray continuation bytes give
// nothing; a zero byte closes the string and flushes an open sequence. The core takes one
// request every cycle while req_bus.ready is high: decode and cursor placement are one short
// combinational pass from the state registers, and a taken request's response enters the
// output stage (output register plus skid) holding earlier responses; ready drops only while
// both entries are full. csr writes take effect at the next edge and are meant for idle time.
`timescale 1ns / 1ps
`include "utf8_decode_text_layout_core_macros.svh"
module utf8_decode_text_layout_core
   import u8dtl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   u8dtl_req_if.sink              req_bus,
   u8dtl_rsp_if.source            rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   state_type  st_ff, st_in;
   state_type  st_step;
   logic       res_valid;
   result_type res;

   // output register and skid entry
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   logic req_fire;
   logic rsp_take;
   logic push;

   assign req_bus.ready = !skid_valid_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_take      = rsp_bus.valid && rsp_bus.ready;
   assign push          = req_fire && res_valid;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata;
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata;
            REG_GLYPH_WIDTH:   cfg_in.glyph_width   = csr_wdata[5:0];
            REG_GLYPH_HEIGHT:  cfg_in.glyph_height  = csr_wdata[5:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // decode and placement of the request byte
   u8dtl_step u_step (
      .state      (st_ff),
      .cfg        (cfg_ff),
      .command    (req_bus.command),
      .byte_value (req_bus.byte_value),
      .start_x    (req_bus.start_x),
      .start_y    (req_bus.start_y),
      .state_next (st_step),
      .res_valid  (res_valid),
      .res        (res)
   );

   assign st_in = req_fire ? st_step : st_ff;

   // two-entry output stage, skid drains into the output register first
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in = res;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.glyph_width   <= RST_GLYPH_WIDTH;
         cfg_ff.glyph_height  <= RST_GLYPH_HEIGHT;
         st_ff                <= '0;
         out_valid_ff         <= 1'b0;
         skid_valid_ff        <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         st_ff         <= st_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.code_point = out_ff.code_point;
   assign rsp_bus.pos_x      = out_ff.pos_x;
   assign rsp_bus.pos_y      = out_ff.pos_y;

   // skid is only ever filled behind a full output register
   `U8DTL_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   // a start request always leaves an open string
   `U8DTL_ASSERT_NEXT(a_start_opens, req_fire && req_bus.command == CMD_START, st_ff.active)
   // a glyph comes only from a text byte of an open string
   `U8DTL_ASSERT_NOW(a_glyph_needs_string, push,
      st_ff.active && req_bus.command == CMD_TEXT)
   // a text byte with no open string leaves the cursor where it was
   `U8DTL_ASSERT_NEXT(a_idle_byte_holds,
      req_fire && req_bus.command == CMD_TEXT && !st_ff.active,
      $stable(st_ff.cursor_x) && $stable(st_ff.cursor_y) && !st_ff.active)

endmodule

// File: rtl/u8dtl_step.sv
// decode of one request byte and glyph placement, combinational
`timescale 1ns / 1ps
module u8dtl_step
   import u8dtl_pkg::*;
(
   input  state_type  state,
   input  cfg_type    cfg,
   input  logic       command,
   input  logic [7:0] byte_value,
   input  logic [7:0] start_x,
   input  logic [7:0] start_y,
   output state_type  state_next,
   output logic       res_valid,
   output result_type res
);

   logic [9:0]  right_sum;
   logic        wrap;
   logic [8:0]  wrap_y;
   logic [9:0]  bottom_sum;
   logic        off_bottom;
   logic [8:0]  place_x;
   logic [8:0]  place_y;
   logic [1:0]  pend_dec;
   logic [15:0] merged_code;
   logic        do_place;
   logic [15:0] place_code;

   // placement of the glyph at the current cursor
   assign right_sum  = {1'b0, state.cursor_x} + 10'(cfg.glyph_width);
   assign wrap       = right_sum > {2'b00, cfg.screen_width};
   assign wrap_y     = 9'(state.cursor_y + 9'(cfg.glyph_height));
   assign bottom_sum = {1'b0, wrap_y} + 10'(cfg.glyph_height);
   assign off_bottom = wrap && (bottom_sum > {2'b00, cfg.screen_height});
   assign place_x    = wrap ? {1'b0, state.home_x} : state.cursor_x;
   assign place_y    = wrap ? wrap_y : state.cursor_y;

   assign pend_dec = state.bytes_pending - 2'd1;

   always_comb begin
      merged_code = state.partial_code;
      unique case (pend_dec)
         2'd0:    merged_code = state.partial_code | {10'd0, byte_value[5:0]};
         2'd1:    merged_code = state.partial_code | {4'd0, byte_value[5:0], 6'd0};
         2'd2:    merged_code = state.partial_code | {byte_value[3:0], 12'd0};
         default: merged_code = state.partial_code;
      endcase
   end

   always_comb begin
      state_next = state;
      do_place   = 1'b0;
      place_code = state.partial_code;
      priority if (command == CMD_START) begin
         state_next.home_x        = start_x;
         state_next.cursor_x      = {1'b0, start_x};
         state_next.cursor_y      = {1'b0, start_y};
         state_next.bytes_pending = 2'd0;
         state_next.skipping      = 1'b0;
         state_next.partial_code  = 16'd0;
         state_next.active        = 1'b1;
      end else if (!state.active) begin
         state_next = state;
      end else if (byte_value == 8'd0) begin
         // terminator, flushes an open 2- or 3-byte sequence
         do_place                 = (state.bytes_pending != 2'd0) && !state.skipping;
         state_next.bytes_pending = 2'd0;
         state_next.skipping      = 1'b0;
         state_next.partial_code  = 16'd0;
         state_next.active        = 1'b0;
      end else if (state.bytes_pending != 2'd0) begin
         state_next.bytes_pending = pend_dec;
         if (state.skipping) begin
            state_next.skipping = pend_dec != 2'd0;
         end else begin
            state_next.partial_code = merged_code;
            place_code              = merged_code;
            do_place                = pend_dec == 2'd0;
         end
      end else if (byte_value[7] == 1'b0) begin
         place_code = {8'd0, byte_value};
         do_place   = 1'b1;
      end else if (byte_value[7:5] == 3'b110) begin
         state_next.partial_code  = {5'd0, byte_value[4:0], 6'd0};
         state_next.bytes_pending = 2'd1;
      end else if (byte_value[7:4] == 4'b1110) begin
         state_next.partial_code  = {byte_value[3:0], 12'd0};
         state_next.bytes_pending = 2'd2;
      end else if (byte_value[7:3] == 5'b11110) begin
         state_next.skipping      = 1'b1;
         state_next.bytes_pending = 2'd3;
      end else begin
         state_next = state;
      end

      res_valid      = 1'b0;
      res.code_point = place_code;
      res.pos_x      = place_x;
      res.pos_y      = place_y;
      if (do_place) begin
         state_next.cursor_x = place_x;
         state_next.cursor_y = place_y;
         if (off_bottom) begin
            state_next.active = 1'b0;
         end else begin
            res_valid           = 1'b1;
            state_next.cursor_x = 9'(place_x + 9'(cfg.glyph_width));
         end
      end
   end

endmodule
